// ===== src/rsa_pkg.sv =====
// ----------------------------------------------------------------------------
// rsa_pkg: shared types and constants of the Rastrigin sum accumulator
// Payload structs, request and mode codes, cosine coefficients, fixed-point
// constants.
// ----------------------------------------------------------------------------
package rsa_pkg;

  // Fraction bits of the coordinate format (Q16.16)
  localparam int FRAC_BITS = 16;

  // Request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  // Variant codes
  localparam logic [1:0] MODE_BASIC   = 2'd0;
  localparam logic [1:0] MODE_SHIFTED = 2'd1;
  localparam logic [1:0] MODE_NONCONT = 2'd2;

  // Register indexes (word address)
  localparam logic REG_VARIANT = 1'b0;

  // Fixed-point constants
  localparam logic [31:0] Q30_ONE  = 32'd1073741824;
  localparam int          SQ_W     = 64 - FRAC_BITS;
  localparam logic [32:0] HALF_VAL = 33'(64'd1 << (FRAC_BITS - 1));
  localparam logic [35:0] CP_RND   = 36'(64'd1 << (29 - FRAC_BITS));
  localparam logic [62:0] SUM_MAX  = {63{1'b1}};

  // Cosine polynomial coefficients, Q30
  localparam logic [30:0] COS_C0 = 31'd1324675879;
  localparam logic [30:0] COS_C1 = 31'd272375560;
  localparam logic [30:0] COS_C2 = 31'd22401995;
  localparam logic [30:0] COS_C3 = 31'd987048;
  localparam logic [30:0] COS_C4 = 31'd27061;

  typedef struct packed {
    logic               req_type;
    logic        [9:0]  coord_index;
    logic signed [31:0] coord_value;
    logic               last_coord;
  } in_data_t;

  typedef struct packed {
    logic [62:0] fitness_sum;
    logic        saturated_flag;
  } out_data_t;

  // One Horner step: coef - (s * acc) >> 30
  function automatic logic [30:0] poly_step(input logic [30:0] s,
                                            input logic [30:0] acc,
                                            input logic [30:0] coef);
    logic [61:0] prod;
    prod = s * acc;
    return coef - prod[60:30];
  endfunction

endpackage

// ===== src/rsa_ram.sv =====
// ----------------------------------------------------------------------------
// rsa_ram: generic single-port-write, single-port-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rsa_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/rastrigin_sum_accumulator.sv =====
// Data path: a coordinate accepted into p1_r moves through p2_r to p9_r, then into the output register.
// Throughput: one item per cycle while the pipeline is not frozen.
// The pipeline freezes only while a finished sum waits on out_stall and the next
// vector end sits in the accumulate stage.
// Reset (rst_n low, synchronous): clears valids, running sum, sticky flag, variant.
// The shift table has no reset; the user must write entries before they are read, the block does not enforce it.
// ----------------------------------------------------------------------------
// rastrigin_sum_accumulator: streaming Rastrigin function evaluator
// Per coordinate t it adds t*t - 10*cos(2*pi*t) + 10 to a running sum and
// emits the sum on the last coordinate. Load items fill a shift table held
// in a synchronous RAM; shifted mode subtracts the entry from the coordinate.
// ----------------------------------------------------------------------------
module rastrigin_sum_accumulator #(
  parameter int MAX_DIM = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  rsa_pkg::in_data_t   in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output rsa_pkg::out_data_t  out_data,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Only the reachable part of the index space gets storage
  localparam int TAB_DEPTH = (MAX_DIM < 1024) ? MAX_DIM : 1024;
  localparam int ADDR_W    = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
  localparam int SQ_LW     = rsa_pkg::SQ_W;

  // --------------------------------------------------------------------------
  // Stage records
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic               vld;
    logic               last;
    logic               inr;    // index lies inside the table
    logic signed [31:0] x;
  } p1_t;

  typedef struct packed {
    logic               vld;
    logic               last;
    logic               sat;
    logic signed [32:0] t;
  } p2_t;

  typedef struct packed {
    logic              vld;
    logic              last;
    logic              sat;
    logic [1:0]        quad;
    logic [30:0]       s;
    logic [30:0]       acc;
    logic [SQ_LW-1:0]  sq;
  } cos_t;

  typedef struct packed {
    logic             vld;
    logic             last;
    logic             sat;
    logic [31:0]      k;
    logic [SQ_LW-1:0] sq;
  } p8_t;

  typedef struct packed {
    logic        vld;
    logic        last;
    logic        sat;
    logic [63:0] term;
  } p9_t;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [1:0] mode_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rsa_pkg::MODE_BASIC;
    end else if (cfg_wr && (paddr[2] == rsa_pkg::REG_VARIANT)) begin
      mode_r <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == rsa_pkg::REG_VARIANT) begin
      prdata = {30'd0, mode_r};
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: the whole pipe advances together; hold it only when a
  // vector end must enter an output register that is still stalled.
  // --------------------------------------------------------------------------
  p1_t  p1_r,  p1_nxt;
  p2_t  p2_r,  p2_nxt;
  cos_t p3_r,  p3_nxt;
  cos_t p4_r,  p4_nxt;
  cos_t p5_r,  p5_nxt;
  cos_t p6_r,  p6_nxt;
  cos_t p7_r,  p7_nxt;
  p8_t  p8_r,  p8_nxt;
  p9_t  p9_r,  p9_nxt;

  logic out_valid_r, out_valid_nxt;
  rsa_pkg::out_data_t out_data_r, out_data_nxt;
  logic [62:0] sum_r, sum_nxt;
  logic        sticky_r, sticky_nxt;

  logic adv;
  logic in_xfer;

  assign adv      = !(out_valid_r && out_stall && p9_r.vld && p9_r.last);
  assign in_stall = !adv;
  assign in_xfer  = in_valid && adv;

  // --------------------------------------------------------------------------
  // Shift table: loads write at their transfer edge, evaluates read at theirs.
  // One transfer per edge, so a read always follows any earlier write.
  // --------------------------------------------------------------------------
  logic              idx_inr;
  logic              tab_we;
  logic              tab_re;
  logic [ADDR_W-1:0] tab_addr;
  logic [31:0]       tab_rdata;

  assign idx_inr  = ({22'd0, in_data.coord_index} < 32'(MAX_DIM));
  assign tab_addr = ADDR_W'(in_data.coord_index);
  assign tab_we   = in_xfer && (in_data.req_type == rsa_pkg::REQ_LOAD) && idx_inr;
  assign tab_re   = in_xfer && (in_data.req_type == rsa_pkg::REQ_EVAL);

  rsa_ram #(
    .DATA_W (32),
    .DEPTH  (TAB_DEPTH)
  ) u_shift_tab (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_addr),
    .wdata (in_data.coord_value),
    .re    (tab_re),
    .raddr (tab_addr),
    .rdata (tab_rdata)
  );

  // Stage 1: capture the coordinate; loads leave the pipe here
  always_comb begin
    p1_nxt      = p1_r;
    p1_nxt.vld  = tab_re;
    p1_nxt.last = in_data.last_coord;
    p1_nxt.inr  = idx_inr;
    p1_nxt.x    = in_data.coord_value;
  end

  // Stage 2: form t per variant
  logic signed [33:0] diff;
  logic signed [31:0] shv;
  logic        [32:0] xmag;
  logic        [33:0] rnd;
  logic        [33:0] vmag;

  always_comb begin
    p2_nxt      = '0;
    p2_nxt.vld  = p1_r.vld;
    p2_nxt.last = p1_r.last;
    p2_nxt.t    = 33'(p1_r.x);
    shv         = p1_r.inr ? $signed(tab_rdata) : 32'sd0;
    diff        = 34'(p1_r.x) - 34'(shv);
    xmag        = p1_r.x[31] ? 33'(-34'(p1_r.x)) : 33'(p1_r.x);
    rnd         = ({1'b0, xmag} << 1) + 34'(rsa_pkg::HALF_VAL);
    vmag        = (rnd >> rsa_pkg::FRAC_BITS) << (rsa_pkg::FRAC_BITS - 1);
    case (mode_r)
      rsa_pkg::MODE_SHIFTED: begin
        if (diff > 34'sd2147483647) begin
          p2_nxt.t   = 33'sd2147483647;
          p2_nxt.sat = 1'b1;
        end else if (diff < -34'sd2147483648) begin
          p2_nxt.t   = -33'sd2147483648;
          p2_nxt.sat = 1'b1;
        end else begin
          p2_nxt.t = diff[32:0];
        end
      end
      rsa_pkg::MODE_NONCONT: begin
        if (xmag >= rsa_pkg::HALF_VAL) begin
          p2_nxt.t = p1_r.x[31] ? 33'(-vmag) : vmag[32:0];
        end
      end
      default: begin
        p2_nxt.t = 33'(p1_r.x);
      end
    endcase
  end

  // Stage 3: square the magnitude, fold the phase into a quarter turn
  logic [31:0] tmag;
  logic [63:0] sq_full;
  logic [39:0] ph_wide;
  logic [15:0] ph;
  logic [14:0] w;
  logic [29:0] ww;

  always_comb begin
    tmag    = p2_r.t[32] ? 32'(-p2_r.t) : p2_r.t[31:0];
    sq_full = tmag * tmag;
    ph_wide = (40'(p2_r.t[rsa_pkg::FRAC_BITS-1:0]) << 16) >> rsa_pkg::FRAC_BITS;
    ph      = ph_wide[15:0];
    w       = ph[14] ? (15'd16384 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
    ww      = w * w;
    p3_nxt      = '0;
    p3_nxt.vld  = p2_r.vld;
    p3_nxt.last = p2_r.last;
    p3_nxt.sat  = p2_r.sat;
    p3_nxt.quad = ph[15:14];
    p3_nxt.s    = {ww[28:0], 2'b00};
    p3_nxt.acc  = rsa_pkg::COS_C4;
    p3_nxt.sq   = sq_full[63:rsa_pkg::FRAC_BITS];
  end

  // Stages 4 to 7: Horner steps of the cosine polynomial, one multiply each
  always_comb begin
    p4_nxt     = p3_r;
    p4_nxt.acc = rsa_pkg::poly_step(p3_r.s, p3_r.acc, rsa_pkg::COS_C3);
    p5_nxt     = p4_r;
    p5_nxt.acc = rsa_pkg::poly_step(p4_r.s, p4_r.acc, rsa_pkg::COS_C2);
    p6_nxt     = p5_r;
    p6_nxt.acc = rsa_pkg::poly_step(p5_r.s, p5_r.acc, rsa_pkg::COS_C1);
    p7_nxt     = p6_r;
    p7_nxt.acc = rsa_pkg::poly_step(p6_r.s, p6_r.acc, rsa_pkg::COS_C0);
  end

  // Stage 8: finish the cosine, clamp, apply quadrant sign, form 1 - cos
  logic        [61:0] cprod;
  logic signed [33:0] cval;
  logic signed [33:0] cneg;

  always_comb begin
    cprod = p7_r.s * p7_r.acc;
    cval  = 34'(rsa_pkg::Q30_ONE) - 34'(cprod[61:30]);
    if (cval > $signed(34'(rsa_pkg::Q30_ONE))) begin
      cval = 34'(rsa_pkg::Q30_ONE);
    end else if (cval < -$signed(34'(rsa_pkg::Q30_ONE))) begin
      cval = -34'(rsa_pkg::Q30_ONE);
    end
    cneg = (p7_r.quad[0] ^ p7_r.quad[1]) ? -cval : cval;
    p8_nxt      = '0;
    p8_nxt.vld  = p7_r.vld;
    p8_nxt.last = p7_r.last;
    p8_nxt.sat  = p7_r.sat;
    p8_nxt.sq   = p7_r.sq;
    p8_nxt.k    = 32'(34'(rsa_pkg::Q30_ONE) - cneg);
  end

  // Stage 9: scale by ten with round half up, add the square
  logic [35:0] cp_wide;
  logic [35:0] cp;

  always_comb begin
    cp_wide = ({4'd0, p8_r.k} << 3) + ({4'd0, p8_r.k} << 1) + rsa_pkg::CP_RND;
    cp      = cp_wide >> (30 - rsa_pkg::FRAC_BITS);
    p9_nxt      = '0;
    p9_nxt.vld  = p8_r.vld;
    p9_nxt.last = p8_r.last;
    p9_nxt.sat  = p8_r.sat;
    p9_nxt.term = 64'(p8_r.sq) + 64'(cp);
  end

  // Accumulate: saturate at the 63-bit maximum, emit and clear on last
  logic [64:0] sum_wide;
  logic        sum_sat;
  logic [62:0] sum_new;
  logic        sticky_new;

  always_comb begin
    sum_wide      = {2'b00, sum_r} + {1'b0, p9_r.term};
    sum_sat       = (sum_wide[64:63] != 2'b00);
    sum_new       = sum_sat ? rsa_pkg::SUM_MAX : sum_wide[62:0];
    sticky_new    = sticky_r || sum_sat || p9_r.sat;
    sum_nxt       = sum_r;
    sticky_nxt    = sticky_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (adv && p9_r.vld) begin
      if (p9_r.last) begin
        sum_nxt                     = '0;
        sticky_nxt                  = 1'b0;
        out_valid_nxt               = 1'b1;
        out_data_nxt.fitness_sum    = sum_new;
        out_data_nxt.saturated_flag = sticky_new;
      end else begin
        sum_nxt    = sum_new;
        sticky_nxt = sticky_new;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Registers: valids and accumulator state reset, payload does not
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r.vld    <= 1'b0;
      p2_r.vld    <= 1'b0;
      p3_r.vld    <= 1'b0;
      p4_r.vld    <= 1'b0;
      p5_r.vld    <= 1'b0;
      p6_r.vld    <= 1'b0;
      p7_r.vld    <= 1'b0;
      p8_r.vld    <= 1'b0;
      p9_r.vld    <= 1'b0;
      sum_r       <= '0;
      sticky_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        p1_r <= p1_nxt;
        p2_r <= p2_nxt;
        p3_r <= p3_nxt;
        p4_r <= p4_nxt;
        p5_r <= p5_nxt;
        p6_r <= p6_nxt;
        p7_r <= p7_nxt;
        p8_r <= p8_nxt;
        p9_r <= p9_nxt;
      end
      sum_r       <= sum_nxt;
      sticky_r    <= sticky_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
